### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/iotw_pkg.sv
`default_nettype none

package iotw_pkg;

    localparam int ID_W            = 16;
    localparam int OP_W            = 2;
    localparam int ST_W            = 3;
    localparam int TO_W            = 4;
    localparam int WHEEL_SLOTS_DEF = 16;
    localparam int CAPACITY_DEF    = 32;

    localparam logic [TO_W-1:0] TIMEOUT_RST = 4'd10;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2
    } t_op;

    typedef enum logic [ST_W-1:0] {
        STS_INSERTED  = 3'd0,
        STS_REFRESHED = 3'd1,
        STS_REMOVED   = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_FULL      = 3'd4,
        STS_EXPIRED   = 3'd5,
        STS_NONE      = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic start;
        logic rd_en;
        logic check;
        logic step;
        logic take;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic hit;
        logic slot_hit;
        logic last_idx;
        logic out_free;
        logic pend_valid;
    } t_sts;

endpackage

`default_nettype wire

### rtl/iotw_in_if.sv
`default_nettype none

interface iotw_in_if;
    logic                      valid;
    logic                      ready;
    logic [iotw_pkg::OP_W-1:0] opcode;
    logic [iotw_pkg::ID_W-1:0] item_id;

    modport source (output valid, output opcode, output item_id, input ready);
    modport sink   (input valid, input opcode, input item_id, output ready);
endinterface

`default_nettype wire

### rtl/iotw_out_if.sv
`default_nettype none

interface iotw_out_if;
    logic                      valid;
    logic                      ready;
    logic [iotw_pkg::ST_W-1:0] status;
    logic [iotw_pkg::ID_W-1:0] out_id;
    logic                      last;

    modport source (output valid, output status, output out_id, output last, input ready);
    modport sink   (input valid, input status, input out_id, input last, output ready);
endinterface

`default_nettype wire

### rtl/idle_timeout_wheel_unit.sv
// Channel   Dir  Handshake      Payload
// i_in_if   in   valid/ready    opcode[1:0], item_id[15:0]
// o_out_if  out  valid/ready    status[2:0], out_id[15:0], last
// i_cfg     in   i_cfg_we       i_cfg_wdata[3:0] (timeout_ticks)
//
// Insert/remove: scans the table entries in order, reading each entry and then
//   checking it; a hit ends the scan. Tick: scans every entry of the table.
//   A full output register stalls both.
// The pace is set by the single-port entry memory with registered read.
// Reset is synchronous; valid bits clear at once, no clearing pass.
// Opcode 3 is accepted in idle and gives no result; the unit stays idle.
`default_nettype none

module idle_timeout_wheel_unit #(
    parameter int WHEEL_SLOTS = iotw_pkg::WHEEL_SLOTS_DEF,
    parameter int CAPACITY    = iotw_pkg::CAPACITY_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [iotw_pkg::TO_W-1:0] i_cfg_wdata,
    iotw_in_if.sink                        i_in_if,
    iotw_out_if.source                     o_out_if
);

    iotw_pkg::t_cmd cmd;
    iotw_pkg::t_sts sts;

    iotw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_if.valid),
        .i_in_opcode (i_in_if.opcode),
        .o_in_ready  (i_in_if.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    iotw_dpath #(
        .WHEEL_SLOTS (WHEEL_SLOTS),
        .CAPACITY    (CAPACITY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_opcode    (i_in_if.opcode),
        .i_item_id   (i_in_if.item_id),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_if    (o_out_if)
    );

endmodule

`default_nettype wire

### rtl/iotw_ctrl.sv
`default_nettype none

module iotw_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [iotw_pkg::OP_W-1:0] i_in_opcode,
    output logic               o_in_ready,
    input  wire iotw_pkg::t_sts i_sts,
    output iotw_pkg::t_cmd     o_cmd
);

    iotw_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iotw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            iotw_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    if (i_in_opcode inside {iotw_pkg::OP_INSERT, iotw_pkg::OP_REMOVE,
                                            iotw_pkg::OP_TICK}) begin
                        n_state = iotw_pkg::S_READ;
                    end
                end
            end
            iotw_pkg::S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = iotw_pkg::S_CHECK;
            end
            iotw_pkg::S_CHECK: begin
                if (i_sts.is_tick) begin
                    if (!(i_sts.slot_hit && i_sts.pend_valid && !i_sts.out_free)) begin
                        o_cmd.take = i_sts.slot_hit;
                        if (i_sts.last_idx) begin
                            n_state = iotw_pkg::S_FINISH;
                        end else begin
                            o_cmd.step = 1'b1;
                            n_state    = iotw_pkg::S_READ;
                        end
                    end
                end else begin
                    o_cmd.check = 1'b1;
                    if (i_sts.hit || i_sts.last_idx) begin
                        n_state = iotw_pkg::S_FINISH;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = iotw_pkg::S_READ;
                    end
                end
            end
            iotw_pkg::S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = iotw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = iotw_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/iotw_dpath.sv
`default_nettype none

module iotw_dpath #(
    parameter int WHEEL_SLOTS = iotw_pkg::WHEEL_SLOTS_DEF,
    parameter int CAPACITY    = iotw_pkg::CAPACITY_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [iotw_pkg::TO_W-1:0] i_cfg_wdata,
    input  wire logic [iotw_pkg::OP_W-1:0] i_opcode,
    input  wire logic [iotw_pkg::ID_W-1:0] i_item_id,
    input  wire iotw_pkg::t_cmd            i_cmd,
    output iotw_pkg::t_sts                 o_sts,
    iotw_out_if.source                     o_out_if
);

    localparam int SW    = $clog2(WHEEL_SLOTS);
    localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int WW    = iotw_pkg::ID_W + SW;
    localparam int TDEPTH = 2 ** iotw_pkg::TO_W;

    logic [iotw_pkg::TO_W-1:0] r_timeout;
    logic [SW-1:0]             r_ptr;
    iotw_pkg::t_op             r_op;
    logic [iotw_pkg::ID_W-1:0] r_id;
    logic [SW-1:0]             r_tgt;
    logic [IW-1:0]             r_idx;
    logic                      r_hit;
    logic [IW-1:0]             r_hit_idx;
    logic                      r_free_found;
    logic [IW-1:0]             r_free_idx;
    logic                      r_pend_valid;
    logic [iotw_pkg::ID_W-1:0] r_pend_id;
    logic [CAPACITY-1:0]       r_valid;
    logic [WW-1:0]             r_mem [CAPACITY];
    logic [WW-1:0]             r_rd_word;

    logic                      r_out_valid;
    logic [iotw_pkg::ST_W-1:0] r_out_status;
    logic [iotw_pkg::ID_W-1:0] r_out_id;
    logic                      r_out_last;

    logic [SW-1:0]             tmod [TDEPTH];
    logic [SW:0]               slot_sum;
    logic [SW-1:0]             slot_new;
    logic [SW-1:0]             ptr_next;
    logic [iotw_pkg::ID_W-1:0] rd_key;
    logic [SW-1:0]             rd_slot;
    logic                      cur_valid;
    logic                      out_free;
    logic                      emit_pend;
    logic                      mem_wr;
    logic [IW-1:0]             mem_wr_addr;
    iotw_pkg::t_status         fin_status;
    logic [iotw_pkg::ID_W-1:0] fin_id;

    for (genvar g = 0; g < TDEPTH; g++) begin : g_tmod
        localparam int TM = g % WHEEL_SLOTS;
        assign tmod[g] = SW'(TM);
    end

    assign slot_sum = {1'b0, r_ptr} + {1'b0, tmod[r_timeout]};
    assign slot_new = (slot_sum >= (SW+1)'(WHEEL_SLOTS)) ?
                      SW'(slot_sum - (SW+1)'(WHEEL_SLOTS)) : slot_sum[SW-1:0];
    assign ptr_next = (r_ptr == SW'(WHEEL_SLOTS - 1)) ? '0 : r_ptr + SW'(1);

    assign rd_key    = r_rd_word[WW-1:SW];
    assign rd_slot   = r_rd_word[SW-1:0];
    assign cur_valid = r_valid[r_idx];
    assign out_free  = !r_out_valid || o_out_if.ready;
    assign emit_pend = i_cmd.take && r_pend_valid;

    assign o_sts.is_tick    = (r_op == iotw_pkg::OP_TICK);
    assign o_sts.hit        = cur_valid && (rd_key == r_id);
    assign o_sts.slot_hit   = cur_valid && (rd_slot == r_ptr);
    assign o_sts.last_idx   = (r_idx == IW'(CAPACITY - 1));
    assign o_sts.out_free   = out_free;
    assign o_sts.pend_valid = r_pend_valid;

    assign mem_wr      = i_cmd.finish && (r_op == iotw_pkg::OP_INSERT) &&
                         (r_hit || r_free_found);
    assign mem_wr_addr = r_hit ? r_hit_idx : r_free_idx;

    always_comb begin
        fin_id = r_id;
        case (r_op)
            iotw_pkg::OP_INSERT: begin
                if (r_hit) begin
                    fin_status = iotw_pkg::STS_REFRESHED;
                end else if (r_free_found) begin
                    fin_status = iotw_pkg::STS_INSERTED;
                end else begin
                    fin_status = iotw_pkg::STS_FULL;
                end
            end
            iotw_pkg::OP_REMOVE: begin
                fin_status = r_hit ? iotw_pkg::STS_REMOVED : iotw_pkg::STS_NOT_FOUND;
            end
            default: begin
                fin_status = r_pend_valid ? iotw_pkg::STS_EXPIRED : iotw_pkg::STS_NONE;
                fin_id     = r_pend_valid ? r_pend_id : '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout    <= iotw_pkg::TIMEOUT_RST;
            r_ptr        <= '0;
            r_op         <= iotw_pkg::OP_INSERT;
            r_idx        <= '0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_pend_valid <= 1'b0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (i_cmd.start) begin
                r_op         <= iotw_pkg::t_op'(i_opcode);
                r_idx        <= '0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
                r_pend_valid <= 1'b0;
                if (i_opcode == iotw_pkg::OP_TICK) begin
                    r_ptr <= ptr_next;
                end
            end
            if (i_cmd.step) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.check) begin
                if (o_sts.hit) begin
                    r_hit <= 1'b1;
                end
                if (!cur_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end
            if (i_cmd.take) begin
                r_pend_valid   <= 1'b1;
                r_valid[r_idx] <= 1'b0;
            end
            if (i_cmd.finish) begin
                if (r_op == iotw_pkg::OP_INSERT && !r_hit && r_free_found) begin
                    r_valid[r_free_idx] <= 1'b1;
                end
                if (r_op == iotw_pkg::OP_REMOVE && r_hit) begin
                    r_valid[r_hit_idx] <= 1'b0;
                end
            end
            if (emit_pend || i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out_if.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_id  <= i_item_id;
            r_tgt <= slot_new;
        end
        if (i_cmd.check && o_sts.hit) begin
            r_hit_idx <= r_idx;
        end
        if (i_cmd.check && !cur_valid && !r_free_found) begin
            r_free_idx <= r_idx;
        end
        if (i_cmd.take) begin
            r_pend_id <= rd_key;
        end
        if (emit_pend) begin
            r_out_status <= iotw_pkg::STS_EXPIRED;
            r_out_id     <= r_pend_id;
            r_out_last   <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_status <= fin_status;
            r_out_id     <= fin_id;
            r_out_last   <= 1'b1;
        end
    end

    // entry table: id and expiry slot
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[mem_wr_addr] <= {r_id, r_tgt};
        end
        if (i_cmd.rd_en) begin
            r_rd_word <= r_mem[r_idx];
        end
    end

    assign o_out_if.valid  = r_out_valid;
    assign o_out_if.status = r_out_status;
    assign o_out_if.out_id = r_out_id;
    assign o_out_if.last   = r_out_last;

endmodule

`default_nettype wire

### rtl/iotw_checker.sv
`default_nettype none
`include "assert_macros.svh"

module iotw_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      i_in_ready,
    input wire logic [iotw_pkg::OP_W-1:0] i_in_opcode,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic [iotw_pkg::ST_W-1:0] i_out_status,
    input wire logic [iotw_pkg::ID_W-1:0] i_out_id,
    input wire logic                      i_out_last
);

    `ASSERT_NEXT(a_rst_out_idle, i_clk, 1'b1, !i_rst_n, !i_out_valid, "output valid after reset")

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_status) && $stable(i_out_id) && $stable(i_out_last), "stalled output changed")

    `ASSERT_IMPLIES(a_single_last, i_clk, i_rst_n, i_out_valid && i_out_status != iotw_pkg::STS_EXPIRED, i_out_last, "single result without last")

    `ASSERT_IMPLIES(a_none_zero, i_clk, i_rst_n, i_out_valid && i_out_status == iotw_pkg::STS_NONE, i_out_id == '0, "nothing-expired result with id")

    `ASSERT_NEXT(a_busy_after_op, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_opcode == iotw_pkg::OP_INSERT || i_in_opcode == iotw_pkg::OP_REMOVE || i_in_opcode == iotw_pkg::OP_TICK), !i_in_ready, "input ready during scan")

endmodule

bind idle_timeout_wheel_unit iotw_checker u_iotw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_if.valid),
    .i_in_ready   (i_in_if.ready),
    .i_in_opcode  (i_in_if.opcode),
    .i_out_valid  (o_out_if.valid),
    .i_out_ready  (o_out_if.ready),
    .i_out_status (o_out_if.status),
    .i_out_id     (o_out_if.out_id),
    .i_out_last   (o_out_if.last)
);

`default_nettype wire
